@@ rtl/kls_pkg.sv @@
// kls_pkg: shared types, codes and character helpers of the keyword lexer
`timescale 1ns / 1ps
`default_nettype none

package kls_pkg;

    localparam int LEN_BITS  = 16;
    localparam int KIND_BITS = 5;
    localparam int MAX_TOKS  = 3;

    // token kinds
    localparam logic [KIND_BITS-1:0] KIND_EXIT  = 5'd0;
    localparam logic [KIND_BITS-1:0] KIND_LET   = 5'd1;
    localparam logic [KIND_BITS-1:0] KIND_IF    = 5'd2;
    localparam logic [KIND_BITS-1:0] KIND_IDENT = 5'd3;
    localparam logic [KIND_BITS-1:0] KIND_INT   = 5'd4;
    localparam logic [KIND_BITS-1:0] KIND_LPAR  = 5'd5;
    localparam logic [KIND_BITS-1:0] KIND_RPAR  = 5'd6;
    localparam logic [KIND_BITS-1:0] KIND_LBRC  = 5'd7;
    localparam logic [KIND_BITS-1:0] KIND_RBRC  = 5'd8;
    localparam logic [KIND_BITS-1:0] KIND_SEMI  = 5'd9;
    localparam logic [KIND_BITS-1:0] KIND_ASGN  = 5'd10;
    localparam logic [KIND_BITS-1:0] KIND_PLUS  = 5'd11;
    localparam logic [KIND_BITS-1:0] KIND_MINUS = 5'd12;
    localparam logic [KIND_BITS-1:0] KIND_STAR  = 5'd13;
    localparam logic [KIND_BITS-1:0] KIND_SLASH = 5'd14;
    localparam logic [KIND_BITS-1:0] KIND_END   = 5'd15;
    localparam logic [KIND_BITS-1:0] KIND_BAD   = 5'd16;

    // keyword lengths
    localparam logic [LEN_BITS-1:0] KW_LEN_EXIT = 16'd4;
    localparam logic [LEN_BITS-1:0] KW_LEN_LET  = 16'd3;
    localparam logic [LEN_BITS-1:0] KW_LEN_IF   = 16'd2;
    localparam logic [LEN_BITS-1:0] LEN_MAX     = 16'hFFFF;

    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_LF   = 8'h0A;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_IDENT   = 3'd1,
        MODE_INT     = 3'd2,
        MODE_COMMENT = 3'd3,
        MODE_HALT    = 3'd4
    } scan_mode_t;

    // pending run state, excluding the character position
    typedef struct packed {
        scan_mode_t          mode;
        logic [LEN_BITS-1:0] run_start;
        logic [LEN_BITS-1:0] run_len;
        logic [2:0]          keyword_alive;
    } scan_state_t;

    localparam scan_state_t SCAN_RESET = '{
        mode: MODE_IDLE, run_start: '0, run_len: '0, keyword_alive: 3'b111};

    typedef struct packed {
        logic [7:0] ch;
        logic       final_char;
    } src_req_t;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [LEN_BITS-1:0]  start_pos;
        logic [LEN_BITS-1:0]  tok_length;
        logic                 run_last;
    } tok_req_t;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [LEN_BITS-1:0]  start_pos;
        logic [LEN_BITS-1:0]  tok_length;
    } tok_t;

    // all results caused by one request
    typedef struct packed {
        logic [1:0]                cnt;
        tok_t [MAX_TOKS-1:0]       tok;
    } bundle_t;

    function automatic logic is_letter(logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    // punctuation lookup, returns KIND_BAD when not punctuation
    function automatic logic [KIND_BITS-1:0] punct_kind(logic [7:0] c);
        logic [KIND_BITS-1:0] k;
        unique case (c)
            8'h28:   k = KIND_LPAR;
            8'h29:   k = KIND_RPAR;
            8'h7B:   k = KIND_LBRC;
            8'h7D:   k = KIND_RBRC;
            8'h3B:   k = KIND_SEMI;
            8'h3D:   k = KIND_ASGN;
            8'h2B:   k = KIND_PLUS;
            8'h2D:   k = KIND_MINUS;
            8'h2A:   k = KIND_STAR;
            8'h2F:   k = KIND_SLASH;
            default: k = KIND_BAD;
        endcase
        return k;
    endfunction

    // keyword letters: 0 exit, 1 let, 2 if
    function automatic logic [7:0] kw_char(logic [1:0] k, logic [1:0] i);
        logic [7:0] c;
        unique case ({k, i})
            4'b00_00: c = 8'h65; // e
            4'b00_01: c = 8'h78; // x
            4'b00_10: c = 8'h69; // i
            4'b00_11: c = 8'h74; // t
            4'b01_00: c = 8'h6C; // l
            4'b01_01: c = 8'h65; // e
            4'b01_10: c = 8'h74; // t
            4'b10_00: c = 8'h69; // i
            4'b10_01: c = 8'h66; // f
            default:  c = 8'h00;
        endcase
        return c;
    endfunction

    // keyword candidates after appending c at offset len
    function automatic logic [2:0] kw_step(logic [2:0] alive, logic [LEN_BITS-1:0] len,
                                           logic [7:0] c);
        logic [2:0] m;
        m[0] = (len < KW_LEN_EXIT) && (kw_char(2'd0, len[1:0]) == c);
        m[1] = (len < KW_LEN_LET)  && (kw_char(2'd1, len[1:0]) == c);
        m[2] = (len < KW_LEN_IF)   && (kw_char(2'd2, len[1:0]) == c);
        return alive & m;
    endfunction

    function automatic logic [LEN_BITS-1:0] len_inc(logic [LEN_BITS-1:0] len);
        return (len == LEN_MAX) ? len : LEN_BITS'(len + 1'b1);
    endfunction

    // token for a pending run
    function automatic tok_t flush_tok(scan_state_t s);
        tok_t t;
        t.start_pos  = s.run_start;
        t.tok_length = s.run_len;
        if (s.mode != MODE_IDENT)
            t.kind = KIND_INT;
        else if (s.keyword_alive[0] && s.run_len == KW_LEN_EXIT)
            t.kind = KIND_EXIT;
        else if (s.keyword_alive[1] && s.run_len == KW_LEN_LET)
            t.kind = KIND_LET;
        else if (s.keyword_alive[2] && s.run_len == KW_LEN_IF)
            t.kind = KIND_IF;
        else
            t.kind = KIND_IDENT;
        return t;
    endfunction

endpackage

`default_nettype wire

@@ rtl/kls_scan.sv @@
// kls_scan: next scan state and result bundle for one source character
`timescale 1ns / 1ps
`default_nettype none

module kls_scan
    import kls_pkg::*;
#(
    parameter int POS_BITS = 16
) (
    input  wire scan_state_t         cur,
    input  wire logic [POS_BITS-1:0] pos,
    input  wire src_req_t            src,
    output scan_state_t              nxt,
    output logic [POS_BITS-1:0]      pos_nxt,
    output bundle_t                  bundle
);

    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    logic [POS_BITS-1:0] pos_inc;
    logic [1:0]          n;
    logic                taken;
    logic [7:0]          c;
    logic [KIND_BITS-1:0] pk;

    always_comb
    begin
        c       = src.ch;
        pk      = punct_kind(c);
        pos_inc = (pos == POS_MAX) ? pos : POS_BITS'(pos + 1'b1);
        nxt     = cur;
        bundle  = '0;
        n       = 2'd0;
        taken   = 1'b0;

        // continue or close the pending run
        unique case (cur.mode)
            MODE_HALT:
            begin
                taken = 1'b1;
            end
            MODE_COMMENT:
            begin
                if (c == CH_LF)
                    nxt.mode = MODE_IDLE;
                taken = 1'b1;
            end
            MODE_IDENT, MODE_INT:
            begin
                if (is_digit(c) || (cur.mode == MODE_IDENT && is_letter(c)))
                begin
                    nxt.keyword_alive = kw_step(cur.keyword_alive, cur.run_len, c);
                    nxt.run_len       = len_inc(cur.run_len);
                    taken             = 1'b1;
                end
                else
                begin
                    bundle.tok[n] = flush_tok(cur);
                    n             = n + 2'd1;
                    nxt.mode      = MODE_IDLE;
                end
            end
            default:
            begin
                nxt.mode = MODE_IDLE;
            end
        endcase

        // character not absorbed by a run, comment or halt
        if (!taken)
        begin
            priority if (is_letter(c) || is_digit(c))
            begin
                nxt.run_start     = 16'(pos);
                nxt.run_len       = 16'd1;
                nxt.keyword_alive = kw_step(3'b111, '0, c);
                nxt.mode          = is_letter(c) ? MODE_IDENT : MODE_INT;
            end
            else if (is_space(c))
            begin
                nxt.mode = nxt.mode;
            end
            else if (c == CH_HASH)
            begin
                nxt.mode = MODE_COMMENT;
            end
            else
            begin
                bundle.tok[n] = '{kind: pk, start_pos: 16'(pos), tok_length: 16'd1};
                n             = n + 2'd1;
                if (pk == KIND_BAD)
                    nxt.mode = MODE_HALT;
            end
        end

        // end of source: close any run, emit end, start afresh
        if (src.final_char)
        begin
            if (nxt.mode == MODE_IDENT || nxt.mode == MODE_INT)
            begin
                bundle.tok[n] = flush_tok(nxt);
                n             = n + 2'd1;
            end
            bundle.tok[n] = '{kind: KIND_END, start_pos: 16'(pos_inc), tok_length: 16'd0};
            n             = n + 2'd1;
            nxt           = SCAN_RESET;
            pos_nxt       = '0;
        end
        else
        begin
            pos_nxt = pos_inc;
        end

        bundle.cnt = n;
    end

endmodule

`default_nettype wire

@@ rtl/kls_queue.sv @@
// kls_queue: two-entry bundle queue that hands out one token per cycle unless stalled
`timescale 1ns / 1ps
`default_nettype none

module kls_queue
    import kls_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire bundle_t bundle,
    output logic         full,
    output logic         valid,
    input  wire logic    stall,
    output tok_req_t     data
);

    bundle_t    mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic [1:0] sub_reg, sub_next;
    bundle_t    head;
    logic       last_tok;
    logic       pop_tok;
    logic       pop_bundle;

    always_comb
    begin
        head            = mem_reg[rd_ptr_reg];
        full            = (count_reg == 2'd2);
        valid           = (count_reg != 2'd0);
        last_tok        = (sub_reg == 2'(head.cnt - 2'd1));
        data.kind       = head.tok[sub_reg].kind;
        data.start_pos  = head.tok[sub_reg].start_pos;
        data.tok_length = head.tok[sub_reg].tok_length;
        data.run_last   = last_tok;

        pop_tok     = valid && !stall;
        pop_bundle  = pop_tok && last_tok;
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop_bundle ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = 2'(count_reg + {1'b0, push} - {1'b0, pop_bundle});
        if (pop_bundle)
            sub_next = 2'd0;
        else if (pop_tok)
            sub_next = sub_reg + 2'd1;
        else
            sub_next = sub_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            sub_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            sub_reg    <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= bundle;
    end

endmodule

`default_nettype wire

@@ rtl/keyword_lexer_stream_top.sv @@
// keyword_lexer_stream_top: streaming tokenizer for identifiers, keywords, integers, punctuation
//
// usage
//   src channel: one source character per request (ch, final_char), final_char
//   on the last character of a source text
//   tok channel: tokens as kind, start_pos, tok_length; run_last marks the last
//   token caused by one character
//   queueing: a taken character's tokens are registered behind earlier bundles
//   throughput: one character per cycle while src_stall is low; a character gives
//   0 to 3 tokens, the tok side hands out one token per cycle while tok_stall is
//   low; bursts drain from a two-entry bundle queue that stalls src only when full
//   reset: queue empty, scanner idle at position zero, src_stall low
//   receiver stall: tokens hold steady; once the queue fills, src is stalled
//   end of source: pending run and end token are emitted, then every piece of
//   scan state returns to its reset value for the next text
//   character position saturates at 2^POS_BITS - 1, run length at 65535
`timescale 1ns / 1ps
`default_nettype none

module keyword_lexer_stream_top
    import kls_pkg::*;
#(
    parameter int POS_BITS = 16
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     src_valid,
    output logic          src_stall,
    input  wire src_req_t src_data,
    output logic          tok_valid,
    input  wire logic     tok_stall,
    output tok_req_t      tok_data
);

    // scanner state, advanced on every taken character
    scan_state_t         scan_reg, scan_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;

    bundle_t bundle;
    logic    accept;
    logic    push;
    logic    full;

    kls_scan #(
        .POS_BITS (POS_BITS)
    ) u_scan (
        .cur     (scan_reg),
        .pos     (pos_reg),
        .src     (src_data),
        .nxt     (scan_next),
        .pos_nxt (pos_next),
        .bundle  (bundle)
    );

    // accept whenever the bundle queue has a free entry
    assign src_stall = full;
    assign accept    = src_valid && !src_stall;
    // characters with no tokens leave the queue untouched
    assign push      = accept && (bundle.cnt != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= SCAN_RESET;
            pos_reg  <= '0;
        end
        else if (accept)
        begin
            scan_reg <= scan_next;
            pos_reg  <= pos_next;
        end
    end

    kls_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .bundle (bundle),
        .full   (full),
        .valid  (tok_valid),
        .stall  (tok_stall),
        .data   (tok_data)
    );

    // end of source leaves the scanner in its reset state
    a_final_resets: assert property (@(posedge clk) disable iff (!rst_n)
        accept && src_data.final_char |=> pos_reg == '0 && scan_reg.mode == MODE_IDLE)
        else $error("scan state not cleared after end of source");

    // halted scanner stays halted until the end of source
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        scan_reg.mode == MODE_HALT && !(accept && src_data.final_char)
        |=> scan_reg.mode == MODE_HALT)
        else $error("halt left before end of source");

    // end token closes the request burst and has no length
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_data.kind == KIND_END |-> tok_data.run_last
        && tok_data.tok_length == 16'd0)
        else $error("end token not last or with length");

    // a burst does not break off before its last token
    a_burst_cont: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_stall && !tok_data.run_last |=> tok_valid)
        else $error("token burst cut short");

endmodule

`default_nettype wire
